/* design/utf8_bitmap_text_renderer_core_assert.svh */
`ifndef UTF8_BITMAP_TEXT_RENDERER_CORE_ASSERT_SVH
`define UTF8_BITMAP_TEXT_RENDERER_CORE_ASSERT_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define UBTR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define UBTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/ubtr_pkg.sv */
package ubtr_pkg;

  localparam int GLYPH_STORE_DEPTH = 4096;
  localparam int MAX_GLYPH_HEIGHT  = 16;
  localparam int MAX_GLYPH_WIDTH   = 8;
  localparam int RESULT_LIMIT      = 16;

  localparam int GS_AW     = $clog2(GLYPH_STORE_DEPTH);
  localparam int ROW_LIMIT = (MAX_GLYPH_HEIGHT < RESULT_LIMIT) ? MAX_GLYPH_HEIGHT : RESULT_LIMIT;
  localparam int RW        = $clog2(ROW_LIMIT + 1);

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_TEXT  = 2'd2;

  localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd0;
  localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd1;
  localparam logic [2:0] REG_FIRST_CODE   = 3'd2;
  localparam logic [2:0] REG_LAST_CODE    = 3'd3;
  localparam logic [2:0] REG_CHAR_SPACING = 3'd4;
  localparam logic [2:0] REG_LINE_PITCH   = 3'd5;
  localparam logic [2:0] REG_BUF_WIDTH    = 3'd6;
  localparam logic [2:0] REG_BUF_HEIGHT   = 3'd7;

  localparam logic [20:0] CODE_LF       = 21'h0A;
  localparam logic [20:0] CODE_CR       = 21'h0D;
  localparam logic [20:0] CODE_QUESTION = 21'h3F;

  localparam logic [7:0] UTF8_CONT_MIN = 8'h80;
  localparam logic [7:0] UTF8_LEAD3    = 8'hE0;
  localparam logic [7:0] UTF8_LEAD4    = 8'hF0;

  typedef struct packed {
    logic [1:0]         command;
    logic [11:0]        glyph_address;
    logic [7:0]         glyph_row;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [7:0]         text_byte;
  } in_req_t;

  typedef struct packed {
    logic [11:0]        row_y;
    logic signed [15:0] col_x;
    logic [7:0]         pixel_mask;
    logic               last_row;
  } out_rsp_t;

  typedef struct packed {
    logic       clear;
    logic       byte_en;
    logic [7:0] data;
  } dec_in_t;

  typedef struct packed {
    logic        code_valid;
    logic [20:0] code;
  } dec_out_t;

endpackage

/* design/ubtr_utf8_dec.sv */
module ubtr_utf8_dec (
  input  logic              clk,
  input  logic              rst_n,
  input  ubtr_pkg::dec_in_t dec_in,
  output ubtr_pkg::dec_out_t dec_out
);
  import ubtr_pkg::*;

  logic [1:0]  pending_r, pending_nxt;
  logic [20:0] partial_r, partial_nxt;
  logic [20:0] joined;

  assign joined = {partial_r[14:0], dec_in.data[5:0]};

  always_comb begin
    dec_out.code_valid = 1'b0;
    dec_out.code       = {13'd0, dec_in.data};
    pending_nxt        = pending_r;
    partial_nxt        = partial_r;
    if (dec_in.clear) begin
      pending_nxt = 2'd0;
      partial_nxt = 21'd0;
    end else if (dec_in.byte_en) begin
      if (pending_r == 2'd0) begin
        if (dec_in.data < UTF8_CONT_MIN) begin
          dec_out.code_valid = 1'b1;
        end else if (dec_in.data < UTF8_LEAD3) begin
          partial_nxt = {16'd0, dec_in.data[4:0]};
          pending_nxt = 2'd1;
        end else if (dec_in.data < UTF8_LEAD4) begin
          partial_nxt = {17'd0, dec_in.data[3:0]};
          pending_nxt = 2'd2;
        end else begin
          partial_nxt = {18'd0, dec_in.data[2:0]};
          pending_nxt = 2'd3;
        end
      end else begin
        pending_nxt  = pending_r - 2'd1;
        dec_out.code = joined;
        if (pending_r == 2'd1) begin
          dec_out.code_valid = 1'b1;
          partial_nxt        = 21'd0;
        end else begin
          partial_nxt = joined;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 2'd0;
      partial_r <= 21'd0;
    end else begin
      pending_r <= pending_nxt;
      partial_r <= partial_nxt;
    end
  end

endmodule

/* design/utf8_bitmap_text_renderer_core.sv */
// Load, start, CR and UTF-8 lead or middle bytes are handled while idle.
// A glyph byte takes lookup (MAP, BASE), then per glyph row inside the buffer
// one glyph store read (ROW) and one result (EMIT), per clipped row only ROW,
// then the advance (ADV, plus NL when the line wraps).
// Synchronous active-low reset restores the register defaults and clears the cursor.
module utf8_bitmap_text_renderer_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ubtr_pkg::in_req_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ubtr_pkg::out_rsp_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import ubtr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAP  = 3'd1;
  localparam logic [2:0] S_BASE = 3'd2;
  localparam logic [2:0] S_ROW  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_ADV  = 3'd5;
  localparam logic [2:0] S_NL   = 3'd6;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  logic [3:0]         gw_r;
  logic [4:0]         gh_r;
  logic [20:0]        first_r, last_r;
  logic signed [6:0]  spacing_r;
  logic [7:0]         pitch_r;
  logic [12:0]        bw_r, bh_r;

  logic [2:0]         state_r, state_nxt;
  logic signed [15:0] cx_r, cx_nxt, cy_r, cy_nxt, home_r, home_nxt;
  logic               stopped_r, stopped_nxt;
  logic [20:0]        code_r, code_nxt;
  logic               have_r, have_nxt;
  logic [GS_AW-1:0]   idx_r, idx_nxt, base_r, base_nxt;
  logic [RW-1:0]      rows_r, rows_nxt, row_r, row_nxt;
  logic [7:0]         colmask_r, colmask_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_rsp_t           out_r, out_nxt;

  logic [7:0]         gstore [GLYPH_STORE_DEPTH];
  logic [7:0]         rd_data_r;
  logic               rd_en;
  logic [GS_AW-1:0]   rd_addr;

  dec_in_t            dec_in;
  dec_out_t           dec_out;

  logic               in_acc, cfg_wr, out_free;
  logic signed [17:0] by, bh_s, bw_s, step_sum, line_sum, bx;
  logic               row_inside, row_is_last, row_final;
  logic [GS_AW+4:0]   base_prod;
  logic [7:0]         pitch_eff;
  logic               code_in, qmark_in;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  assign dec_in.clear   = in_acc && (in_data.command == CMD_START);
  assign dec_in.byte_en = in_acc && (in_data.command == CMD_TEXT) && !stopped_r;
  assign dec_in.data    = in_data.text_byte;

  ubtr_utf8_dec u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .dec_in  (dec_in),
    .dec_out (dec_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r      <= 4'd8;
      gh_r      <= 5'd8;
      first_r   <= 21'd32;
      last_r    <= 21'd127;
      spacing_r <= 7'sd0;
      pitch_r   <= 8'd0;
      bw_r      <= 13'd320;
      bh_r      <= 13'd240;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_GLYPH_WIDTH:  gw_r      <= pwdata[3:0];
        REG_GLYPH_HEIGHT: gh_r      <= pwdata[4:0];
        REG_FIRST_CODE:   first_r   <= pwdata[20:0];
        REG_LAST_CODE:    last_r    <= pwdata[20:0];
        REG_CHAR_SPACING: spacing_r <= pwdata[6:0];
        REG_LINE_PITCH:   pitch_r   <= pwdata[7:0];
        REG_BUF_WIDTH:    bw_r      <= pwdata[12:0];
        REG_BUF_HEIGHT:   bh_r      <= pwdata[12:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_GLYPH_WIDTH:  prdata = {28'd0, gw_r};
      REG_GLYPH_HEIGHT: prdata = {27'd0, gh_r};
      REG_FIRST_CODE:   prdata = {11'd0, first_r};
      REG_LAST_CODE:    prdata = {11'd0, last_r};
      REG_CHAR_SPACING: prdata = {25'd0, spacing_r};
      REG_LINE_PITCH:   prdata = {24'd0, pitch_r};
      REG_BUF_WIDTH:    prdata = {19'd0, bw_r};
      REG_BUF_HEIGHT:   prdata = {19'd0, bh_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_data.command == CMD_LOAD)) begin
      gstore[GS_AW'(in_data.glyph_address)] <= in_data.glyph_row;
    end
    if (rd_en) begin
      rd_data_r <= gstore[rd_addr];
    end
  end

  assign bh_s       = $signed({5'd0, bh_r});
  assign bw_s       = $signed({5'd0, bw_r});
  assign by         = $signed({{2{cy_r[15]}}, cy_r}) + $signed({{(18-RW){1'b0}}, row_r});
  assign row_inside = !by[17] && (by < bh_s);
  assign row_final  = ({1'b0, row_r} + {{RW{1'b0}}, 1'b1}) == {1'b0, rows_r};
  assign row_is_last = row_final || ((by + 18'sd1) >= bh_s);
  assign rd_en      = (state_r == S_ROW) && row_inside;
  assign rd_addr    = base_r + GS_AW'(row_r);
  assign base_prod  = idx_r * gh_r;
  assign pitch_eff  = (pitch_r != 8'd0) ? pitch_r : {3'd0, gh_r};
  assign step_sum   = $signed({{2{cx_r[15]}}, cx_r}) + $signed({14'd0, gw_r})
                    + $signed({{11{spacing_r[6]}}, spacing_r});
  assign line_sum   = $signed({{2{cy_r[15]}}, cy_r}) + $signed({10'd0, pitch_eff});
  assign code_in    = (code_r >= first_r) && (code_r <= last_r);
  assign qmark_in   = (CODE_QUESTION >= first_r) && (CODE_QUESTION <= last_r);

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      bx = $signed({{2{cx_r[15]}}, cx_r}) + 18'(c);
      colmask_nxt[c] = (c < MAX_GLYPH_WIDTH) && (4'(c) < gw_r) && !bx[17] && (bx < bw_s);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    home_nxt      = home_r;
    stopped_nxt   = stopped_r;
    code_nxt      = code_r;
    have_nxt      = have_r;
    idx_nxt       = idx_r;
    base_nxt      = base_r;
    rows_nxt      = rows_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_data.command == CMD_START)) begin
          cx_nxt      = in_data.origin_x;
          home_nxt    = in_data.origin_x;
          cy_nxt      = in_data.origin_y;
          stopped_nxt = 1'b0;
        end else if (dec_in.byte_en && dec_out.code_valid) begin
          if (dec_out.code == CODE_LF) begin
            state_nxt = S_NL;
          end else if (dec_out.code == CODE_CR) begin
            cx_nxt = home_r;
          end else begin
            code_nxt  = dec_out.code;
            state_nxt = S_MAP;
          end
        end
      end
      S_MAP: begin
        have_nxt  = code_in || qmark_in;
        idx_nxt   = code_in ? GS_AW'(code_r - first_r) : GS_AW'(CODE_QUESTION - first_r);
        state_nxt = S_BASE;
      end
      S_BASE: begin
        base_nxt  = base_prod[GS_AW-1:0];
        rows_nxt  = (gh_r > 5'(ROW_LIMIT)) ? RW'(ROW_LIMIT) : RW'(gh_r);
        row_nxt   = '0;
        state_nxt = (have_r && (gh_r != 5'd0)) ? S_ROW : S_ADV;
      end
      S_ROW: begin
        if (row_inside) begin
          state_nxt = S_EMIT;
        end else if (row_final) begin
          state_nxt = S_ADV;
        end else begin
          row_nxt = row_r + RW'(1);
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_nxt.row_y    = by[11:0];
          out_nxt.col_x    = cx_r;
          out_nxt.last_row = row_is_last;
          for (int c = 0; c < 8; c++) begin
            out_nxt.pixel_mask[c] = rd_data_r[7-c] & colmask_r[c];
          end
          row_nxt   = row_r + RW'(1);
          state_nxt = row_final ? S_ADV : S_ROW;
        end
      end
      S_ADV: begin
        cx_nxt    = sat16(step_sum);
        state_nxt = (step_sum >= bw_s) ? S_NL : S_IDLE;
      end
      S_NL: begin
        cx_nxt      = home_r;
        cy_nxt      = sat16(line_sum);
        stopped_nxt = stopped_r || (line_sum >= bh_s);
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cx_r        <= 16'sd0;
      cy_r        <= 16'sd0;
      home_r      <= 16'sd0;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      rows_r      <= '0;
      row_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      home_r      <= home_nxt;
      stopped_r   <= stopped_nxt;
      out_valid_r <= out_valid_nxt;
      rows_r      <= rows_nxt;
      row_r       <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r    <= code_nxt;
    have_r    <= have_nxt;
    idx_r     <= idx_nxt;
    base_r    <= base_nxt;
    out_r     <= out_nxt;
    if (state_r == S_BASE) begin
      colmask_r <= colmask_nxt;
    end
  end

`include "utf8_bitmap_text_renderer_core_assert.svh"

  `UBTR_ASSERT_SAME(a_row_in_range, state_r == S_ROW || state_r == S_EMIT, row_r < rows_r, "row counter beyond glyph rows")
  `UBTR_ASSERT_NEXT(a_emit_holds, state_r == S_EMIT && !out_free, state_r == S_EMIT, "row result dropped while output busy")
  `UBTR_ASSERT_NEXT(a_stopped_ignores, in_valid && in_ready && stopped_r && in_data.command == CMD_TEXT, state_r == S_IDLE, "text byte processed while stopped")
  `UBTR_ASSERT_SAME(a_ready_only_idle, state_r != S_IDLE, !in_ready, "request taken while rendering")

endmodule

/* verif/tb_utf8_bitmap_text_renderer_core.sv */
`timescale 1ns / 1ps

module tb_utf8_bitmap_text_renderer_core;
  import ubtr_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 60;
  localparam int PRELOAD_ROWS = 32;

  typedef struct {
    int gw;
    int gh;
    int first_code;
    int last_code;
    int spacing;
    int pitch;
    int bw;
    int bh;
  } render_cfg_t;

  class text_render_board;
    logic [7:0]  glyph_mem [GLYPH_STORE_DEPTH];
    int          cur_x, cur_y, home_x, pending;
    logic [20:0] partial;
    bit          stopped;
    int          gw, gh, first_code, last_code, spacing, pitch, bw, bh;
    out_rsp_t    pending_rows [$];
    int          failures, rows_checked, requests_taken, live_requests;

    function new();
      cur_x = 0;
      cur_y = 0;
      home_x = 0;
      pending = 0;
      partial = '0;
      stopped = 1'b0;
      gw = 8;
      gh = 8;
      first_code = 32;
      last_code = 127;
      spacing = 0;
      pitch = 0;
      bw = 320;
      bh = 240;
      failures = 0;
      rows_checked = 0;
      requests_taken = 0;
      live_requests = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      logic signed [6:0] s7;
      s7 = v[6:0];
      case (idx)
        REG_GLYPH_WIDTH:  gw = v[3:0];
        REG_GLYPH_HEIGHT: gh = v[4:0];
        REG_FIRST_CODE:   first_code = v[20:0];
        REG_LAST_CODE:    last_code = v[20:0];
        REG_CHAR_SPACING: spacing = s7;
        REG_LINE_PITCH:   pitch = v[7:0];
        REG_BUF_WIDTH:    bw = v[12:0];
        REG_BUF_HEIGHT:   bh = v[12:0];
        default: ;
      endcase
    endfunction

    static function int sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
    endfunction

    function void advance_line();
      cur_x = home_x;
      cur_y = sat16(longint'(cur_y) + ((pitch != 0) ? pitch : gh));
      if (cur_y >= bh) stopped = 1'b1;
    endfunction

    function void draw(int code);
      bit         have, have_held;
      longint     base, by, bx;
      int         rows, cols;
      logic [7:0] bits, mask;
      out_rsp_t   held;
      have = 1'b1;
      have_held = 1'b0;
      held = '0;
      if (code < first_code || code > last_code) begin
        code = CODE_QUESTION;
        if (code < first_code || code > last_code) have = 1'b0;
      end
      if (have) begin
        base = longint'(code - first_code) * gh;
        rows = (gh > ROW_LIMIT) ? ROW_LIMIT : gh;
        cols = (gw > MAX_GLYPH_WIDTH) ? MAX_GLYPH_WIDTH : gw;
        for (int r = 0; r < rows; r++) begin
          by = longint'(cur_y) + r;
          if (by < 0 || by >= bh) continue;
          bits = glyph_mem[(base + r) % GLYPH_STORE_DEPTH];
          mask = '0;
          for (int c = 0; c < cols; c++) begin
            bx = longint'(cur_x) + c;
            if (bx >= 0 && bx < bw && bits[7 - c]) mask[c] = 1'b1;
          end
          if (have_held) pending_rows.push_back(held);
          held.row_y = by[11:0];
          held.col_x = cur_x[15:0];
          held.pixel_mask = mask;
          held.last_row = 1'b0;
          have_held = 1'b1;
        end
        if (have_held) begin
          held.last_row = 1'b1;
          pending_rows.push_back(held);
        end
      end
      cur_x = sat16(longint'(cur_x) + gw + spacing);
      if (cur_x >= bw) advance_line();
    endfunction

    function void take_request(in_req_t r);
      logic [7:0] b;
      int         code;
      requests_taken++;
      case (r.command)
        CMD_LOAD: begin
          glyph_mem[r.glyph_address] = r.glyph_row;
          live_requests++;
        end
        CMD_START: begin
          home_x = int'($signed(r.origin_x));
          cur_x = home_x;
          cur_y = int'($signed(r.origin_y));
          stopped = 1'b0;
          pending = 0;
          partial = '0;
          live_requests++;
        end
        CMD_TEXT: begin
          if (!stopped) begin
            live_requests++;
            b = r.text_byte;
            if (pending == 0) begin
              if (b < UTF8_CONT_MIN) begin
                code = b;
              end else begin
                if (b < UTF8_LEAD3) begin
                  partial = b & 8'h1F;
                  pending = 1;
                end else if (b < UTF8_LEAD4) begin
                  partial = b & 8'h0F;
                  pending = 2;
                end else begin
                  partial = b & 8'h07;
                  pending = 3;
                end
                return;
              end
            end else begin
              partial = {partial[14:0], b[5:0]};
              pending--;
              if (pending != 0) return;
              code = partial;
              partial = '0;
            end
            if (code == CODE_LF) advance_line();
            else if (code == CODE_CR) cur_x = home_x;
            else draw(code);
          end
        end
        default: ;
      endcase
    endfunction

    function void fail(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void match_row(out_rsp_t got);
      out_rsp_t want;
      if (pending_rows.size() == 0) begin
        fail($sformatf("Unexpected row: row_y=%0d col_x=%0d mask=%02h last=%0b",
                       got.row_y, got.col_x, got.pixel_mask, got.last_row));
        return;
      end
      want = pending_rows.pop_front();
      rows_checked++;
      if (got.row_y !== want.row_y || got.col_x !== want.col_x ||
          got.pixel_mask !== want.pixel_mask || got.last_row !== want.last_row) begin
        fail($sformatf({"Row mismatch: expected row_y=%0d col_x=%0d mask=%02h last=%0b, ",
                        "got row_y=%0d col_x=%0d mask=%02h last=%0b"},
                       want.row_y, want.col_x, want.pixel_mask, want.last_row,
                       got.row_y, got.col_x, got.pixel_mask, got.last_row));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_req_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_rsp_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  text_render_board board;
  render_cfg_t      cur_cfg;
  in_req_t          burst [$];
  int               snd_idle = 0;
  int               rcv_idle = 0;
  bit               hold_go = 1'b0;
  int               hold_cnt = 0;
  int               cycle_count = 0;
  int               settings_used = 0;

  utf8_bitmap_text_renderer_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.take_request(in_data);
      if (out_valid && out_ready) board.match_row(out_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_go && hold_cnt < HOLD_CYCLES) begin
      out_ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  function automatic render_cfg_t mk_cfg(int gw, int gh, int fc, int lc, int sp, int lp,
                                         int bw, int bh);
    render_cfg_t s;
    s.gw = gw;
    s.gh = gh;
    s.first_code = fc;
    s.last_code = lc;
    s.spacing = sp;
    s.pitch = lp;
    s.bw = bw;
    s.bh = bh;
    return s;
  endfunction

  function automatic in_req_t noise_req(logic [1:0] cmd);
    in_req_t t;
    t.command = cmd;
    t.glyph_address = 12'($urandom);
    t.glyph_row = 8'($urandom);
    t.origin_x = 16'($urandom);
    t.origin_y = 16'($urandom);
    t.text_byte = 8'($urandom);
    return t;
  endfunction

  function automatic in_req_t text_req(logic [7:0] b);
    in_req_t t;
    t = noise_req(CMD_TEXT);
    t.text_byte = b;
    return t;
  endfunction

  function automatic in_req_t start_req(int x, int y);
    in_req_t t;
    t = noise_req(CMD_START);
    t.origin_x = x[15:0];
    t.origin_y = y[15:0];
    return t;
  endfunction

  function automatic void push_code(int code);
    logic [7:0] enc [$];
    int         n;
    if (code < 'h80) begin
      enc.push_back(code[7:0]);
    end else if (code < 'h800) begin
      enc.push_back(8'hC0 | code[10:6]);
      enc.push_back(8'h80 | code[5:0]);
    end else if (code < 'h10000) begin
      enc.push_back(8'hE0 | code[15:12]);
      enc.push_back(8'h80 | code[11:6]);
      enc.push_back(8'h80 | code[5:0]);
    end else begin
      enc.push_back(8'hF0 | code[20:18]);
      enc.push_back(8'h80 | code[17:12]);
      enc.push_back(8'h80 | code[11:6]);
      enc.push_back(8'h80 | code[5:0]);
    end
    n = enc.size();
    if (n > 1 && $urandom_range(0, 3) == 0) begin
      for (int i = 1; i < n; i++) enc[i][7:6] = 2'($urandom);
    end
    if (n > 1 && $urandom_range(0, 9) == 0) n--;
    for (int i = 0; i < n; i++) burst.push_back(text_req(enc[i]));
  endfunction

  function automatic void fill_burst();
    int      pick, code, span, ox, oy;
    in_req_t t;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      t = noise_req(CMD_START);
      if ($urandom_range(0, 7) != 0) begin
        ox = int'($urandom_range(0, cur_cfg.bw + 7)) - 8;
        oy = int'($urandom_range(0, cur_cfg.bh + cur_cfg.gh)) - cur_cfg.gh;
        t.origin_x = ox[15:0];
        t.origin_y = oy[15:0];
      end
      burst.push_back(t);
    end else if (pick < 12) begin
      burst.push_back(noise_req(CMD_LOAD));
    end else if (pick < 14) begin
      burst.push_back(noise_req(CMD_UNUSED));
    end else if (pick < 20) begin
      burst.push_back(text_req($urandom_range(0, 1) ? CODE_LF[7:0] : CODE_CR[7:0]));
    end else if (pick < 28) begin
      burst.push_back(text_req(8'($urandom)));
    end else begin
      if (pick < 36 || cur_cfg.last_code < cur_cfg.first_code) begin
        code = $urandom_range(0, 'h1FFFFF);
      end else begin
        span = cur_cfg.last_code - cur_cfg.first_code;
        if (span > 95 && $urandom_range(0, 1)) span = 95;
        code = cur_cfg.first_code + int'($urandom_range(0, span));
      end
      push_code(code);
    end
  endfunction

  task automatic offer_request(input in_req_t t);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (board.pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_reg(idx, value);
  endtask

  task automatic apply_setting(input render_cfg_t s);
    write_reg(REG_GLYPH_WIDTH, s.gw);
    write_reg(REG_GLYPH_HEIGHT, s.gh);
    write_reg(REG_FIRST_CODE, s.first_code);
    write_reg(REG_LAST_CODE, s.last_code);
    write_reg(REG_CHAR_SPACING, s.spacing & 'h7F);
    write_reg(REG_LINE_PITCH, s.pitch);
    write_reg(REG_BUF_WIDTH, s.bw);
    write_reg(REG_BUF_HEIGHT, s.bh);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_cfg = s;
    settings_used++;
  endtask

  task automatic run_random(input render_cfg_t s, input int count);
    int base;
    apply_setting(s);
    base = board.live_requests;
    while (board.live_requests - base < count) begin
      fill_burst();
      while (burst.size() != 0) offer_request(burst.pop_front());
    end
    settle_block();
  endtask

  // Every setting keeps the rows of all drawable glyphs inside the preloaded part
  // of the glyph store, so no unwritten entry is ever read.
  initial begin
    in_req_t t;
    board = new();
    cur_cfg = mk_cfg(8, 8, 32, 127, 0, 0, 320, 240);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle = 37;
    rcv_idle = 71;
    for (int a = 0; a < PRELOAD_ROWS; a++) begin
      t = noise_req(CMD_LOAD);
      t.glyph_address = a[11:0];
      offer_request(t);
    end
    settle_block();
    apply_setting(mk_cfg(8, 8, 62, 65, 0, 0, 320, 240));

    burst.push_back(start_req(0, 0));
    burst.push_back(text_req(8'h41));
    burst.push_back(text_req(8'hC3));
    burst.push_back(text_req(8'hA9));
    burst.push_back(text_req(8'hE2));
    burst.push_back(text_req(8'h82));
    burst.push_back(text_req(8'hAC));
    burst.push_back(text_req(8'hF0));
    burst.push_back(text_req(8'h9F));
    burst.push_back(text_req(8'h98));
    burst.push_back(text_req(8'h80));
    burst.push_back(text_req(CODE_LF[7:0]));
    burst.push_back(text_req(CODE_CR[7:0]));
    burst.push_back(start_req(-3, -5));
    burst.push_back(text_req(8'h5A));
    burst.push_back(start_req(32767, 32767));
    burst.push_back(text_req(8'h42));
    burst.push_back(text_req(8'h43));
    burst.push_back(noise_req(CMD_UNUSED));
    burst.push_back(noise_req(CMD_LOAD));
    burst.push_back(start_req(-32768, 0));
    burst.push_back(text_req(8'hFF));
    burst.push_back(text_req(8'h00));
    burst.push_back(text_req(8'hFF));
    burst.push_back(text_req(8'h3F));
    while (burst.size() != 0) offer_request(burst.pop_front());
    settle_block();

    run_random(mk_cfg(1, 1, 1114111, 1114111, -8, 255, 1, 1), 7);
    run_random(mk_cfg(8, 16, 0, 1, 0, 0, 4096, 4096), 7);

    snd_idle = 71;
    rcv_idle = 37;
    run_random(mk_cfg(5, 7, 61, 64, 32, 3, 100, 60), 6);
    run_random(mk_cfg(8, 16, 62, 63, -3, 0, 37, 200), 6);

    snd_idle = 0;
    rcv_idle = 0;
    hold_go <= 1'b1;
    burst.push_back(start_req(0, 0));
    run_random(mk_cfg(3, 12, 63, 64, 2, 20, 50, 4096), 7);
    run_random(mk_cfg(6, 9, 0, 2, -8, 255, 4096, 1), 5);

    $display("Summary: %0d requests taken, %0d glyph rows checked under %0d register settings.",
             board.requests_taken, board.rows_checked, settings_used);
    $display("Summary: UTF-8 of one to four bytes, clipping, wrap, stop, and a %0d-cycle hold.",
             HOLD_CYCLES);
    if (board.failures == 0 && board.pending_rows.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failures, %0d rows still expected.", board.failures,
               board.pending_rows.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/ubtr_pkg.sv
design/ubtr_utf8_dec.sv
design/utf8_bitmap_text_renderer_core.sv
verif/tb_utf8_bitmap_text_renderer_core.sv
